// ===== rtl/rcw_pkg.sv =====
// Shared constants and codes for the ray-cast wall column pixel unit.
`default_nettype none
package rcw_pkg;

    localparam int SCREEN_HEIGHT = 480;
    localparam int SCREEN_MID    = SCREEN_HEIGHT / 2;
    localparam int TEX_SIZE      = 64;
    localparam int TEXTURE_COUNT = 8;
    localparam int TEX_W         = $clog2(TEX_SIZE);
    localparam int TID_W         = 3;

    // Fixed-point widths.
    localparam int DIST_W  = 24;
    localparam int ANGLE_W = 12;
    localparam int PERP_W  = 25;
    localparam int COS_W   = 15;
    localparam int H_W     = 32;

    localparam logic [29:0] PI_Q28  = 30'd843314857;
    localparam logic [28:0] Q28_ONE = 29'h1000_0000;
    localparam logic [11:0] QUARTER_TURN = 12'd1024;

    // Horner divisors and their reciprocals scaled by 2^30, rounded down.
    localparam int HORNER_STEPS = 5;
    localparam logic [6:0]  HORNER_K [HORNER_STEPS] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [29:0] HORNER_M [HORNER_STEPS] =
        '{30'd11930464, 30'd19173961, 30'd35791394, 30'd89478485, 30'd536870912};

    localparam logic [7:0] CFG_TILE_SIZE       = 8'd0;
    localparam logic [7:0] CFG_PROJ_PLANE_DIST = 8'd1;
    localparam logic [7:0] CFG_CEILING_COLOR   = 8'd2;
    localparam logic [7:0] CFG_FLOOR_COLOR     = 8'd3;

    localparam logic [7:0]  TILE_SIZE_RST       = 8'd64;
    localparam logic [15:0] PROJ_PLANE_DIST_RST = 16'd554;
    localparam logic [31:0] CEILING_COLOR_RST   = 32'hFF87CEEB;
    localparam logic [31:0] FLOOR_COLOR_RST     = 32'h00555555;

    localparam logic [1:0] PIX_CEILING = 2'd0;
    localparam logic [1:0] PIX_WALL    = 2'd1;
    localparam logic [1:0] PIX_FLOOR   = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/raycast_wall_column_pixel_unit.sv =====
// Top level of the ray-cast wall column pixel unit.
// Takes one pixel request per beat and returns one classified pixel per beat. The
// pipeline accepts a new beat every clock unless the result beat is held. Its stages are
// the cosine and distance correction, the strip height divider (one quotient bit per
// stage), the row classification register, the texel row divider and one output
// register. When the result beat is held by a low m_tready, every stage holds.
// Configuration registers are written through the cfg port, which is always ready;
// write them only while no beat is in flight.
`default_nettype none
module raycast_wall_column_pixel_unit import rcw_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // Input beats.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // ray_distance[23:0], angle_delta[35:24], hit_x[51:36], hit_y[67:52],
    // wall_kind[71:68], row[80:72], zero fill above
    input  wire logic [87:0] s_tdata,
    // hit_vertical[0]
    input  wire logic [0:0]  s_tuser,
    // Result beats.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // fill_color[31:0], texture_id[34:32], tex_col[40:35], tex_row[46:41], zero fill above
    output logic [47:0]      m_tdata,
    // pixel_kind[1:0]
    output logic [1:0]       m_tuser
);

    localparam int SIDE0_W = 9 + TEX_W + TID_W;
    localparam int SIDE1_W = 2 + TEX_W + TID_W;

    logic [7:0]  tile_size_reg;
    logic [15:0] proj_plane_dist_reg;
    logic [31:0] ceiling_color_reg;
    logic [31:0] floor_color_reg;

    logic en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_size_reg       <= TILE_SIZE_RST;
            proj_plane_dist_reg <= PROJ_PLANE_DIST_RST;
            ceiling_color_reg   <= CEILING_COLOR_RST;
            floor_color_reg     <= FLOOR_COLOR_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TILE_SIZE:       tile_size_reg       <= cfg_data[7:0];
                CFG_PROJ_PLANE_DIST: proj_plane_dist_reg <= cfg_data[15:0];
                CFG_CEILING_COLOR:   ceiling_color_reg   <= cfg_data;
                CFG_FLOOR_COLOR:     floor_color_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input unpacking and the per-beat fields that need no arithmetic.
    logic [DIST_W-1:0]  s_dist;
    logic [ANGLE_W-1:0] s_angle;
    logic [15:0]        s_hit_x;
    logic [15:0]        s_hit_y;
    logic [3:0]         s_wall_kind;
    logic [8:0]         s_row;
    logic [3:0]         kind_m1;
    logic [TID_W-1:0]   tid;
    logic [TEX_W-1:0]   tex_col;
    logic [SIDE0_W-1:0] side0;

    assign s_dist      = s_tdata[23:0];
    assign s_angle     = s_tdata[35:24];
    assign s_hit_x     = s_tdata[51:36];
    assign s_hit_y     = s_tdata[67:52];
    assign s_wall_kind = s_tdata[71:68];
    assign s_row       = s_tdata[80:72];

    // Wall kind zero wraps; texture numbers beyond the set clamp to the last one.
    assign kind_m1 = s_wall_kind + 4'hF;
    assign tid     = (5'(kind_m1) >= 5'(TEXTURE_COUNT)) ? TID_W'(TEXTURE_COUNT - 1)
                                                        : TID_W'(kind_m1);
    assign tex_col = s_tuser[0] ? s_hit_y[TEX_W-1:0] : s_hit_x[TEX_W-1:0];
    assign side0   = {s_row, tex_col, tid};

    assign s_tready = en;

    logic               cp_valid;
    logic [PERP_W-1:0]  cp_perp;
    logic [SIDE0_W-1:0] cp_side;

    rcw_cos_perp #(.SIDE_W(SIDE0_W)) u_cos_perp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_dist   (s_dist),
        .in_angle  (s_angle),
        .in_side   (side0),
        .out_valid (cp_valid),
        .out_perp  (cp_perp),
        .out_side  (cp_side)
    );

    logic [H_W-1:0] height_num;

    assign height_num = {24'(tile_size_reg) * 24'(proj_plane_dist_reg), 8'd0};

    logic               hd_valid;
    logic [H_W-1:0]     hd_h;
    logic [SIDE0_W-1:0] hd_side;

    rcw_div_pipe #(.Q_W(H_W), .D_W(PERP_W), .SIDE_W(SIDE0_W)) u_height_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cp_valid),
        .in_rem    ('0),
        .in_bits   (height_num),
        .in_den    (cp_perp),
        .in_side   (cp_side),
        .out_valid (hd_valid),
        .out_quot  (hd_h),
        .out_side  (hd_side)
    );

    // Row classification against the clipped strip.
    logic [30:0] half_h;
    logic        half_big;
    logic [31:0] row_w;
    logic [31:0] top_w;
    logic [31:0] bottom_w;
    logic [1:0]  kind_next;
    logic [31:0] from_top_next;

    assign half_h        = hd_h[H_W-1:1];
    assign half_big      = (half_h >= 31'(SCREEN_MID));
    assign row_w         = 32'(hd_side[SIDE0_W-1:TEX_W+TID_W]);
    assign top_w         = half_big ? 32'd0 : (32'(SCREEN_MID) - {1'b0, half_h});
    assign bottom_w      = half_big ? 32'(SCREEN_HEIGHT) : (32'(SCREEN_MID) + {1'b0, half_h});
    assign from_top_next = row_w + {1'b0, half_h} - 32'(SCREEN_MID);
    assign kind_next     = (row_w < top_w) ? PIX_CEILING :
                           (row_w < bottom_w) ? PIX_WALL : PIX_FLOOR;

    logic               cls_valid_reg;
    logic [1:0]         cls_kind_reg;
    logic [31:0]        cls_from_top_reg;
    logic [H_W-1:0]     cls_h_reg;
    logic [TEX_W+TID_W-1:0] cls_tex_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cls_valid_reg <= 1'b0;
        end else if (en) begin
            cls_valid_reg <= hd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cls_kind_reg     <= kind_next;
            cls_from_top_reg <= from_top_next;
            cls_h_reg        <= hd_h;
            cls_tex_reg      <= hd_side[TEX_W+TID_W-1:0];
        end
    end

    // Offset into the strip is below the height, so only texel-row bits remain.
    logic               td_valid;
    logic [TEX_W-1:0]   td_row;
    logic [SIDE1_W-1:0] td_side;

    rcw_div_pipe #(.Q_W(TEX_W), .D_W(H_W), .SIDE_W(SIDE1_W)) u_texrow_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cls_valid_reg),
        .in_rem    (cls_from_top_reg),
        .in_bits   ('0),
        .in_den    (cls_h_reg),
        .in_side   ({cls_kind_reg, cls_tex_reg}),
        .out_valid (td_valid),
        .out_quot  (td_row),
        .out_side  (td_side)
    );

    logic [1:0] td_kind;

    assign td_kind = td_side[SIDE1_W-1:SIDE1_W-2];

    logic             m_valid_reg;
    logic [1:0]       m_kind_reg;
    logic [31:0]      m_fill_reg;
    logic [TID_W-1:0] m_tid_reg;
    logic [TEX_W-1:0] m_col_reg;
    logic [TEX_W-1:0] m_row_reg;

    assign en = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= td_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_kind_reg <= td_kind;
            case (td_kind)
                PIX_CEILING: begin
                    m_fill_reg <= ceiling_color_reg;
                    m_tid_reg  <= '0;
                    m_col_reg  <= '0;
                    m_row_reg  <= '0;
                end
                PIX_WALL: begin
                    m_fill_reg <= '0;
                    m_tid_reg  <= td_side[TID_W-1:0];
                    m_col_reg  <= td_side[TEX_W+TID_W-1:TID_W];
                    m_row_reg  <= td_row;
                end
                default: begin
                    m_fill_reg <= floor_color_reg;
                    m_tid_reg  <= '0;
                    m_col_reg  <= '0;
                    m_row_reg  <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {1'b0, m_row_reg, m_col_reg, m_tid_reg, m_fill_reg};

endmodule
`default_nettype wire

// ===== rtl/rcw_cos_perp.sv =====
// Pipelined fixed-point cosine and fish-eye corrected ray distance.
`default_nettype none
module rcw_cos_perp import rcw_pkg::*; #(
    parameter int SIDE_W = 18
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [DIST_W-1:0]  in_dist,
    input  wire logic [ANGLE_W-1:0] in_angle,
    input  wire logic [SIDE_W-1:0]  in_side,
    output logic                    out_valid,
    output logic [PERP_W-1:0]       out_perp,
    output logic [SIDE_W-1:0]       out_side
);

    localparam int LAT = 20;

    logic              v_reg    [LAT];
    logic [SIDE_W-1:0] side_reg [LAT];
    logic [DIST_W-1:0] dist_reg [LAT-1];
    logic              ov_reg   [18];

    logic [11:0] u_next;
    logic [10:0] u_reg;
    logic [40:0] x_prod;
    logic [28:0] x_reg;
    logic [57:0] x2_prod;
    logic [29:0] x2_reg [13];

    logic [29:0] a_reg  [HORNER_STEPS];
    logic [29:0] a2_reg [HORNER_STEPS];
    logic [28:0] qe_reg [HORNER_STEPS];
    logic [28:0] t_reg  [HORNER_STEPS];

    logic [28:0] cos_sum;
    logic [COS_W-1:0] cos_reg;
    logic [38:0] perp_prod;
    logic [PERP_W-1:0] perp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            dist_reg[0] <= in_dist;
            for (int i = 1; i < LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 1; i < LAT - 1; i++) begin
                dist_reg[i] <= dist_reg[i-1];
            end
        end
    end

    // Absolute angle; anything past a quarter turn has a cosine of zero.
    assign u_next  = in_angle[ANGLE_W-1] ? (~in_angle + 12'd1) : in_angle;
    assign x_prod  = 41'(u_reg) * 41'(PI_Q28);
    assign x2_prod = 58'(x_reg) * 58'(x_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg     <= u_next[10:0];
            ov_reg[0] <= (u_next > QUARTER_TURN);
            x_reg     <= x_prod[39:11];
            x2_reg[0] <= x2_prod[57:28];
            for (int i = 1; i < 18; i++) begin
                ov_reg[i] <= ov_reg[i-1];
            end
            for (int i = 1; i < 13; i++) begin
                x2_reg[i] <= x2_reg[i-1];
            end
        end
    end

    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
        logic [28:0] t_in;
        logic [58:0] a_prod;
        logic [59:0] qe_prod;
        logic [29:0] r_next;
        logic [29:0] q_next;
        logic [28:0] t_next;

        if (j == 0) begin : g_first
            assign t_in = Q28_ONE;
        end else begin : g_rest
            assign t_in = t_reg[j-1];
        end

        assign a_prod  = 59'(x2_reg[3*j]) * 59'(t_in);
        assign qe_prod = 60'(a_reg[j]) * 60'(HORNER_M[j]);

        // The reciprocal estimate is at most one low; one compare fixes it.
        always_comb begin
            r_next = a2_reg[j] - 30'(qe_reg[j] * 36'(HORNER_K[j]));
            q_next = 30'(qe_reg[j]) + ((r_next >= 30'(HORNER_K[j])) ? 30'd1 : 30'd0);
            t_next = (q_next >= 30'(Q28_ONE)) ? 29'd0 : (Q28_ONE - q_next[28:0]);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[j]  <= a_prod[57:28];
                a2_reg[j] <= a_reg[j];
                qe_reg[j] <= qe_prod[58:30];
                t_reg[j]  <= t_next;
            end
        end
    end

    assign cos_sum   = t_reg[HORNER_STEPS-1] + 29'd8192;
    assign perp_prod = 39'(dist_reg[LAT-2]) * 39'(cos_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg  <= ov_reg[17] ? '0 : cos_sum[28:14];
            perp_reg <= perp_prod[38:14];
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign out_side  = side_reg[LAT-1];
    assign out_perp  = perp_reg;

endmodule
`default_nettype wire

// ===== rtl/rcw_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rcw_div_pipe #(
    parameter int Q_W    = 32,
    parameter int D_W    = 25,
    parameter int SIDE_W = 18
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [D_W-1:0]    in_rem,
    input  wire logic [Q_W-1:0]    in_bits,
    input  wire logic [D_W-1:0]    in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [Q_W-1:0]         out_quot,
    output logic [SIDE_W-1:0]      out_side
);

    logic              v_reg    [Q_W];
    logic [D_W-1:0]    rem_reg  [Q_W];
    logic [Q_W-1:0]    bits_reg [Q_W];
    logic [Q_W-1:0]    quot_reg [Q_W];
    logic [D_W-1:0]    den_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    // A zero divisor gives all quotient bits set, which is the saturated value.
    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic              v_in;
        logic [D_W-1:0]    rem_in;
        logic [Q_W-1:0]    bits_in;
        logic [Q_W-1:0]    quot_in;
        logic [D_W-1:0]    den_in;
        logic [SIDE_W-1:0] side_in;
        logic [D_W:0]      sh;
        logic              ge;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_rem;
            assign bits_in = in_bits;
            assign quot_in = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign bits_in = bits_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign sh = {rem_in, bits_in[Q_W-1]};
        assign ge = (sh >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? D_W'(sh - {1'b0, den_in}) : D_W'(sh);
                bits_reg[i] <= {bits_in[Q_W-2:0], 1'b0};
                quot_reg[i] <= {quot_in[Q_W-2:0], ge};
                den_reg[i]  <= den_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule
`default_nettype wire

// ===== dv/raycast_wall_column_pixel_unit_tb.sv =====
// Self-checking testbench for the ray-cast wall column pixel unit.
`timescale 1ns / 1ps
module raycast_wall_column_pixel_unit_tb import rcw_pkg::*;;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    raycast_wall_column_pixel_unit DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic [23:0] ray_dist;
        logic [11:0] angle;
        logic        vert;
        logic [15:0] hx;
        logic [15:0] hy;
        logic [3:0]  kind;
        logic [8:0]  row;
    } ray_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] fill;
        logic [2:0]  tid;
        logic [5:0]  col;
        logic [5:0]  trow;
    } pixel_t;

    typedef struct {
        ray_req_t req;
        logic     known;
        pixel_t   pix;
    } dir_row_t;

    logic [7:0]  tile_sz;
    logic [15:0] plane_dist;
    logic [31:0] ceil_col;
    logic [31:0] floor_col;

    pixel_t pending_pixels[$];
    int     errors = 0;
    int     pixels_seen = 0;
    int     counts[3] = '{0, 0, 0};
    int     phase_no = 0;
    logic   drain_hold = 1'b0;
    longint cycle = 0;

    function automatic logic [63:0] cosine_q14(logic [11:0] a);
        logic [63:0] u, x, x2, t, sub;
        logic [63:0] divs[5];
        divs = '{64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
        u = a[11] ? ((64'h1000 - a) & 64'hFFF) : a[10:0];
        if (u > 1024) return 0;
        x = (u * 64'd843314857) >> 11;
        x2 = (x * x) >> 28;
        t = 64'd1 << 28;
        for (int k = 0; k < 5; k++) begin
            sub = ((x2 * t) >> 28) / divs[k];
            t = (sub >= (64'd1 << 28)) ? 0 : (64'd1 << 28) - sub;
        end
        return (t + 64'd8192) >> 14;
    endfunction

    function automatic pixel_t project_pixel(ray_req_t r);
        pixel_t p;
        logic [63:0] perp, h, tid, from_top;
        longint half_h, top, bottom, row;
        perp = (64'(r.ray_dist) * cosine_q14(r.angle)) >> 14;
        if (perp == 0) h = 64'hFFFF_FFFF;
        else h = (64'(tile_sz) * 64'(plane_dist) * 256) / perp;
        if (h > 64'hFFFF_FFFF) h = 64'hFFFF_FFFF;
        half_h = longint'(h / 2);
        top = SCREEN_MID - half_h;
        if (top < 0) top = 0;
        bottom = SCREEN_MID + half_h;
        if (bottom > SCREEN_HEIGHT) bottom = SCREEN_HEIGHT;
        row = longint'(r.row);
        p = '0;
        if (row < top) begin
            p.kind = PIX_CEILING;
            p.fill = ceil_col;
        end else if (row < bottom) begin
            p.kind = PIX_WALL;
            tid = (64'(r.kind) + 15) & 64'hF;
            if (tid >= TEXTURE_COUNT) tid = TEXTURE_COUNT - 1;
            p.tid = tid[2:0];
            p.col = r.vert ? r.hy[5:0] : r.hx[5:0];
            from_top = 64'(row + half_h - SCREEN_MID);
            p.trow = 6'((from_top * TEX_SIZE) / h);
        end else begin
            p.kind = PIX_FLOOR;
            p.fill = floor_col;
        end
        return p;
    endfunction

    // The caller drops cfg_valid once its burst of writes is done.
    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TILE_SIZE:       tile_sz = val[7:0];
            CFG_PROJ_PLANE_DIST: plane_dist = val[15:0];
            CFG_CEILING_COLOR:   ceil_col = val;
            CFG_FLOOR_COLOR:     floor_col = val;
            default: ;
        endcase
    endtask

    // The valid stays up after a beat so back-to-back beats need no gap.
    task automatic send_ray(ray_req_t r, logic known, pixel_t want);
        int gap;
        pixel_t p;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
        p = project_pixel(r);
        if (known && p !== want) begin
            errors++;
            $display("%0t: directed row disagrees with predictor: table %h predictor %h",
                     $time, want, p);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, r.row, r.kind, r.hy, r.hx, r.angle, r.ray_dist};
        s_tuser <= r.vert;
        do @(posedge aclk); while (!s_tready);
        pending_pixels.push_back(known ? want : p);
    endtask

    function automatic ray_req_t random_ray();
        ray_req_t r;
        r.ray_dist = ($urandom_range(0, 3) == 0) ? 24'($urandom) :
                     24'($urandom_range(64, 40000));
        r.angle = ($urandom_range(0, 7) == 0) ? 12'($urandom) :
                  12'($urandom_range(0, 1400) - 700);
        r.vert = 1'($urandom);
        r.hx = 16'($urandom);
        r.hy = 16'($urandom);
        r.kind = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        r.row = ($urandom_range(0, 15) == 0) ? 9'($urandom) : 9'($urandom_range(0, 479));
        return r;
    endfunction

    // Receiver: random stalls per beat, plus a long hold-off when asked.
    initial begin
        pixel_t got, want;
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
            if (gap > 0 || drain_hold) m_tready <= 1'b0;
            repeat (gap) @(posedge aclk);
            while (drain_hold) @(posedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = {m_tuser, m_tdata[31:0], m_tdata[34:32], m_tdata[40:35], m_tdata[46:41]};
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel beat %h", $time, got);
            end else begin
                want = pending_pixels.pop_front();
                if (got.kind < 3) counts[got.kind]++;
                if (got !== want) begin
                    errors++;
                    $display("%0t: pixel mismatch: expected kind %0d fill %h tid %0d col %0d row %0d,",
                             $time, want.kind, want.fill, want.tid, want.col, want.trow);
                    $display("    actual kind %0d fill %h tid %0d col %0d row %0d",
                             got.kind, got.fill, got.tid, got.col, got.trow);
                end
            end
        end
    end

    // Long receiver hold-off in the third phase, long enough to fill the pipeline.
    initial begin
        wait (phase_no == 2);
        repeat (40) @(posedge aclk);
        drain_hold <= 1'b1;
        repeat (1000) @(posedge aclk);
        drain_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > 2_000_000) begin
            $display("Timeout after %0d cycles", cycle);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    initial begin
        dir_row_t dir[$];
        dir_row_t d;
        ray_req_t r;
        pixel_t none;
        logic [31:0] cfg_sets[4][4];

        tile_sz = TILE_SIZE_RST;
        plane_dist = PROJ_PLANE_DIST_RST;
        ceil_col = CEILING_COLOR_RST;
        floor_col = FLOOR_COLOR_RST;
        none = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, with reset registers in place.
        // Zero distance fills the screen: row 0 is wall, just under mid texture.
        d.req = '{24'd0, 12'd0, 1'b0, 16'd70, 16'd0, 4'd1, 9'd0};
        d.known = 1; d.pix = '{PIX_WALL, 32'd0, 3'd0, 6'd6, 6'd31}; dir.push_back(d);
        // Angle beyond a quarter turn saturates the height too.
        d.req = '{24'd1000, 12'h800, 1'b1, 16'd0, 16'hFFFF, 4'd8, 9'd479};
        d.known = 1; d.pix = '{PIX_WALL, 32'd0, 3'd7, 6'd63, 6'd32}; dir.push_back(d);
        // Very far wall: tiny strip, top row ceiling, bottom row floor.
        d.req = '{24'hFFFFFF, 12'd0, 1'b0, 16'd0, 16'd0, 4'd2, 9'd0};
        d.known = 1; d.pix = '{PIX_CEILING, CEILING_COLOR_RST, 3'd0, 6'd0, 6'd0}; dir.push_back(d);
        d.req = '{24'hFFFFFF, 12'd0, 1'b0, 16'd0, 16'd0, 4'd2, 9'd479};
        d.known = 1; d.pix = '{PIX_FLOOR, FLOOR_COLOR_RST, 3'd0, 6'd0, 6'd0}; dir.push_back(d);
        // Rows past the screen height are floor.
        d.req = '{24'd0, 12'd0, 1'b0, 16'd0, 16'd0, 4'd1, 9'd511};
        d.known = 1; d.pix = '{PIX_FLOOR, FLOOR_COLOR_RST, 3'd0, 6'd0, 6'd0}; dir.push_back(d);
        // Wall kinds out of range: zero wraps, large ones saturate.
        d.req = '{24'd0, 12'd0, 1'b1, 16'd0, 16'd5, 4'd0, 9'd100};
        d.known = 1; d.pix = '{PIX_WALL, 32'd0, 3'd7, 6'd5, 6'd31}; dir.push_back(d);
        d.req = '{24'd0, 12'd0, 1'b0, 16'd0, 16'd0, 4'd15, 9'd200};
        d.known = 0; dir.push_back(d);
        // Quarter-turn edges and mid-range distances, predictor-checked.
        foreach (cfg_sets[i]) ;
        d.known = 0;
        d.req = '{24'd5000, 12'd1024, 1'b0, 16'd7, 16'd0, 4'd3, 9'd240}; dir.push_back(d);
        d.req = '{24'd5000, 12'hC00, 1'b1, 16'd0, 16'd9, 4'd4, 9'd240}; dir.push_back(d);
        d.req = '{24'd5000, 12'd1025, 1'b0, 16'd0, 16'd0, 4'd5, 9'd240}; dir.push_back(d);
        d.req = '{24'd16384, 12'd300, 1'b0, 16'd33, 16'd0, 4'd6, 9'd150}; dir.push_back(d);
        d.req = '{24'd16384, 12'hED4, 1'b1, 16'd0, 16'd44, 4'd7, 9'd330}; dir.push_back(d);
        d.req = '{24'd40000, 12'd0, 1'b0, 16'd1, 16'd0, 4'd8, 9'd239}; dir.push_back(d);
        d.req = '{24'd40000, 12'd0, 1'b0, 16'd1, 16'd0, 4'd8, 9'd300}; dir.push_back(d);
        foreach (dir[i]) send_ray(dir[i].req, dir[i].known, dir[i].pix);
        wait_idle();

        // Register settings, extremes included; an out-of-range index is ignored.
        cfg_sets = '{'{32'd1, 32'd1, 32'h0, 32'hFFFF_FFFF},
                     '{32'd255, 32'd65535, 32'hFFFF_FFFF, 32'h0},
                     '{32'd64, 32'd554, 32'h1234_5678, 32'h9ABC_DEF0},
                     '{32'd16, 32'd300, 32'hFF87CEEB, 32'h00555555}};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                for (int k = 0; k < 4; k++) write_reg(8'(k), cfg_sets[ph - 1][k]);
                write_reg(8'd4 + 8'($urandom_range(0, 200)), $urandom);
                cfg_valid <= 1'b0;
            end
            phase_no = ph;
            for (int n = 0; n < 380; n++) begin
                r = random_ray();
                send_ray(r, 1'b0, none);
            end
            wait_idle();
        end

        $display("Checked %0d pixel beats over five register settings:", pixels_seen);
        $display("  %0d ceiling, %0d wall, %0d floor", counts[0], counts[1], counts[2]);
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
